// ----- rtl/bfps_pkg.sv -----
// bfps_pkg: shared types, constants and helpers for the byte fifo peek/skip block
// no dependencies; imported by every module under rtl
package bfps_pkg;

  // queue capacity in bytes
  localparam int DEPTH  = 4096;
  localparam int ADDR_W = $clog2(DEPTH);
  // held count must reach DEPTH itself
  localparam int HELD_W = $clog2(DEPTH + 1);
  // width of the count fields on the ports
  localparam int CNT_W  = 13;
  localparam int OFS_W  = 12;
  // working width for pointer sums and count compares
  localparam int WIDE_W = ((HELD_W > CNT_W) ? HELD_W : CNT_W) + 1;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_SKIP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_DROP  = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [7:0]         data_in;
    logic [OFS_W-1:0]   peek_offset;
    logic [CNT_W-1:0]   skip_count;
  } bfps_in_t;

  typedef struct packed {
    logic [7:0]         data_out;
    logic               data_valid;
    logic [CNT_W-1:0]   moved_count;
    logic [CNT_W-1:0]   fill_level;
    status_t            status;
  } bfps_out_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_EXEC    = 2'd1,
    S_PRESENT = 2'd2
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic present;
  } bfps_cmd_t;

  // pointer advance modulo DEPTH; p < DEPTH and n <= DEPTH so one subtract suffices
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] p,
                                                 input logic [WIDE_W-1:0] n);
    logic [WIDE_W-1:0] sum;
    sum = WIDE_W'(p) + n;
    if (sum >= WIDE_W'(DEPTH)) begin
      sum = sum - WIDE_W'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/bfps_ctrl.sv -----
// bfps_ctrl: request sequencer, idle -> execute -> present
// depends on bfps_pkg
module bfps_ctrl
  import bfps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output bfps_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.present = 1'b0;
    busy        = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_PRESENT;
      end
      S_PRESENT: begin
        cmd.present = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bfps_dp.sv -----
// bfps_dp: byte store, head/tail pointers, fill count and result registers
// depends on bfps_pkg; driven by bfps_ctrl commands
module bfps_dp
  import bfps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bfps_cmd_t cmd,
  input  bfps_in_t  in_data,
  output bfps_out_t out_data
);

  logic [7:0]        mem [DEPTH];
  bfps_in_t          req_r;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [7:0]        rd_data_r;
  logic              valid_r, valid_nxt;
  logic [CNT_W-1:0]  moved_r, moved_nxt;
  status_t           status_r, status_nxt;

  logic              we, re;
  logic [ADDR_W-1:0] rd_addr;
  logic [WIDE_W-1:0] held_w, count_w, offset_w, skip_n;

  always_comb begin
    held_w   = WIDE_W'(held_r);
    count_w  = WIDE_W'(req_r.skip_count);
    offset_w = WIDE_W'(req_r.peek_offset);
    skip_n   = (count_w > held_w) ? held_w : count_w;

    head_nxt   = head_r;
    tail_nxt   = tail_r;
    held_nxt   = held_r;
    valid_nxt  = 1'b0;
    moved_nxt  = '0;
    status_nxt = ST_OK;
    we         = 1'b0;
    re         = 1'b0;
    rd_addr    = head_r;

    case (req_r.mode)
      MODE_WRITE: begin
        if (held_w >= WIDE_W'(DEPTH)) begin
          status_nxt = ST_DROP;
        end else begin
          we        = cmd.exec;
          tail_nxt  = wrap_add(tail_r, WIDE_W'(1));
          held_nxt  = held_r + HELD_W'(1);
          moved_nxt = CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (held_r == '0) begin
          status_nxt = ST_SHORT;
        end else begin
          re        = cmd.exec;
          valid_nxt = 1'b1;
          head_nxt  = wrap_add(head_r, WIDE_W'(1));
          held_nxt  = held_r - HELD_W'(1);
          moved_nxt = CNT_W'(1);
        end
      end
      MODE_PEEK: begin
        rd_addr = wrap_add(head_r, offset_w);
        if (offset_w >= held_w) begin
          status_nxt = ST_SHORT;
        end else begin
          re        = cmd.exec;
          valid_nxt = 1'b1;
        end
      end
      MODE_SKIP: begin
        if (count_w > held_w) begin
          status_nxt = ST_SHORT;
        end
        head_nxt  = wrap_add(head_r, skip_n);
        held_nxt  = HELD_W'(held_w - skip_n);
        moved_nxt = CNT_W'(skip_n);
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[tail_r] <= req_r.data_in;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.exec) begin
      valid_r  <= valid_nxt;
      moved_r  <= moved_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      held_r <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      held_r <= held_nxt;
    end
  end

  always_comb begin
    out_data.data_out    = valid_r ? rd_data_r : 8'd0;
    out_data.data_valid  = valid_r;
    out_data.moved_count = moved_r;
    out_data.fill_level  = CNT_W'(held_r);
    out_data.status      = status_r;
  end

`ifndef ASSERT_OFF
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WIDE_W'(held_r) <= WIDE_W'(DEPTH))
    else $error("fill count above capacity");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ((WIDE_W'(head_r) + WIDE_W'(held_r)) == WIDE_W'(tail_r)) ||
    ((WIDE_W'(head_r) + WIDE_W'(held_r)) == (WIDE_W'(tail_r) + WIDE_W'(DEPTH))))
    else $error("head, tail and fill count disagree");

  a_state_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.exec) |-> ($stable(head_r) && $stable(tail_r) && $stable(held_r)))
    else $error("queue state changed outside execute");

  a_valid_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.present && valid_r) |-> (status_r == ST_OK))
    else $error("byte returned with non-ok status");
`endif

endmodule

// ----- rtl/byte_fifo_peek_skip.sv -----
// byte_fifo_peek_skip: top level of the circular byte queue with peek and skip
// depends on bfps_pkg, bfps_ctrl and bfps_dp
//
// Circular byte queue of DEPTH (4096) bytes. Raise start with a request on
// in_data while busy is low; the transaction is taken at that clock edge.
// Modes: write appends data_in (dropped with status 2 when full), read pops
// the oldest byte (status 1 when empty), peek returns the byte peek_offset
// places behind the oldest without removing it (status 1 when the offset is
// not below the fill), skip discards up to skip_count bytes, clamped to the
// fill (status 1 when clamped). Exactly one result comes back per request,
// on out_data for a single cycle marked by out_valid; the strobe is raised in
// the present state, which follows the execute state after the accept, and
// the result is taken at the edge that ends it. The receiver cannot stall it
// and must take it then. A request goes through three steps: accept, execute
// for the byte store access and pointer update, and present for the registered
// read data; busy is high in execute and present, so the next request waits.
// The store has no reset; the fill count guards every read.
module byte_fifo_peek_skip
  import bfps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  // request channel
  input  logic      start,
  output logic      busy,
  input  bfps_in_t  in_data,
  // result channel, one-cycle strobe
  output logic      out_valid,
  output bfps_out_t out_data
);

  bfps_cmd_t cmd;

  // sequencer: capture, execute, present
  bfps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // byte store, pointers and result registers
  bfps_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // result is shown only in the present cycle
  assign out_valid = cmd.present;

`ifndef ASSERT_OFF
  a_one_cycle_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("no result two cycles after accept");

  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("idle while a result is shown");
`endif

endmodule
